### rtl/ofr_pkg.sv
package ofr_pkg;

  localparam int InWidth     = 32;
  localparam int OutFracBits = 30;

  // Magnitude width that each axis is normalized to before the norm
  localparam int NormBits  = 31;
  // One square root step per result bit of a 64-bit radicand
  localparam int SqrtSteps = 32;
  localparam int SumBits   = 64;
  localparam int RootBits  = 32;

  // Per-axis values that ride along the norm and divide pipeline
  typedef struct packed {
    logic                     nz;
    logic [2:0]               neg;
    logic [2:0][NormBits-1:0] c;
  } axis_t;

endpackage

### rtl/ofr_cross.sv
module ofr_cross #(
  parameter int W = ofr_pkg::InWidth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic [2:0][W-1:0]       pos_i,
  input  logic [2:0][W-1:0]       vel_i,
  output logic                    vld_o,
  output logic [2:0][W-1:0]       vel_o,
  output logic [2:0][2*W:0]       cr_o
);
  localparam int PW = 2 * W;
  localparam int CW = 2 * W + 1;

  logic signed [PW-1:0] pa_q [3];
  logic signed [PW-1:0] pb_q [3];
  logic [2:0][W-1:0]    vel1_q, vel2_q;
  logic [2:0][CW-1:0]   cr_q;
  logic                 v1_q, v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
    end
  end

  // v cross p, products first, differences next stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q[0] <= $signed(vel_i[1]) * $signed(pos_i[2]);
      pb_q[0] <= $signed(vel_i[2]) * $signed(pos_i[1]);
      pa_q[1] <= $signed(vel_i[2]) * $signed(pos_i[0]);
      pb_q[1] <= $signed(vel_i[0]) * $signed(pos_i[2]);
      pa_q[2] <= $signed(vel_i[0]) * $signed(pos_i[1]);
      pb_q[2] <= $signed(vel_i[1]) * $signed(pos_i[0]);
      vel1_q  <= vel_i;
      for (int k = 0; k < 3; k++) begin
        cr_q[k] <= CW'(pa_q[k]) - CW'(pb_q[k]);
      end
      vel2_q  <= vel1_q;
    end
  end

  assign vld_o = v2_q;
  assign vel_o = vel2_q;
  assign cr_o  = cr_q;

endmodule

### rtl/ofr_unit.sv
module ofr_unit #(
  parameter int W = ofr_pkg::InWidth,
  parameter int F = ofr_pkg::OutFracBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [2:0][W-1:0]     a_i,
  output logic                  vld_o,
  output logic                  nz_o,
  output logic [2:0][F+1:0]     u_o
);
  import ofr_pkg::*;

  localparam int SW = W + NormBits;
  localparam int AW = $clog2(SW + 1);

  function automatic logic [AW-1:0] bit_len(logic [W-1:0] v);
    logic [AW-1:0] n;
    n = '0;
    for (int i = 0; i < W; i++) begin
      if (v[i]) n = AW'(i + 1);
    end
    return n;
  endfunction

  // stage 1: magnitudes
  logic [2:0][W-1:0] mag1_d, mag1_q, mag2_q;
  logic [2:0]        neg1_q, neg2_q;
  logic              v1_q, v2_q, v3_q, v4_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag1_d[k] = a_i[k][W-1] ? -a_i[k] : a_i[k];
    end
  end

  // stage 2: common bit length
  logic [AW-1:0] len2_d, amt2_q;
  logic          shr2_q, nz2_q;

  assign len2_d = bit_len(mag1_q[0] | mag1_q[1] | mag1_q[2]);

  // stage 3: shift to NormBits bits
  axis_t meta3_d, meta3_q, meta4_q;

  always_comb begin
    logic [SW-1:0] ext;
    logic [SW-1:0] sh;
    meta3_d.nz  = nz2_q;
    meta3_d.neg = neg2_q;
    for (int k = 0; k < 3; k++) begin
      ext = {{NormBits{1'b0}}, mag2_q[k]};
      sh  = shr2_q ? (ext >> amt2_q) : (ext << amt2_q);
      meta3_d.c[k] = sh[NormBits-1:0];
    end
  end

  // stage 4: squares
  logic [2:0][2*NormBits-1:0] sq4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q <= mag1_d;
      for (int k = 0; k < 3; k++) neg1_q[k] <= a_i[k][W-1];
      mag2_q <= mag1_q;
      neg2_q <= neg1_q;
      nz2_q  <= len2_d != '0;
      shr2_q <= len2_d > AW'(NormBits);
      amt2_q <= (len2_d > AW'(NormBits)) ? len2_d - AW'(NormBits)
                                         : AW'(NormBits) - len2_d;
      meta3_q <= meta3_d;
      for (int k = 0; k < 3; k++) begin
        sq4_q[k] <= meta3_q.c[k] * meta3_q.c[k];
      end
      meta4_q <= meta3_q;
    end
  end

  // stage 5 and square root steps
  logic [SumBits-1:0] sx_q [SqrtSteps+1];
  logic [SumBits-1:0] sr_q [SqrtSteps+1];
  axis_t              sm_q [SqrtSteps+1];
  logic               sv_q [SqrtSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (en_i) begin
      sv_q[0] <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q[0] <= SumBits'(sq4_q[0]) + SumBits'(sq4_q[1]) + SumBits'(sq4_q[2]);
      sr_q[0] <= '0;
      sm_q[0] <= meta4_q;
    end
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam logic [SumBits-1:0] Bit = SumBits'(1) << (SumBits - 2 - 2 * k);
    logic [SumBits:0] trial;
    logic             take;

    assign trial = {1'b0, sr_q[k]} + {1'b0, Bit};
    assign take  = {1'b0, sx_q[k]} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else if (en_i) begin
        sv_q[k+1] <= sv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sx_q[k+1] <= take ? sx_q[k] - trial[SumBits-1:0] : sx_q[k];
        sr_q[k+1] <= take ? (sr_q[k] >> 1) + Bit : sr_q[k] >> 1;
        sm_q[k+1] <= sm_q[k];
      end
    end
  end

  // restoring division, one quotient bit per stage
  logic [2:0][F:0]          dq_q   [F+1];
  logic [2:0][RootBits-1:0] drem_q [F+1];
  logic [RootBits-1:0]      dr_q   [F+1];
  axis_t                    dm_q   [F+1];
  logic                     dv_q   [F+1];

  always_comb begin
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_q[0] <= sv_q[SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dr_q[0] <= sr_q[SqrtSteps][RootBits-1:0];
      dm_q[0] <= sm_q[SqrtSteps];
      for (int k = 0; k < 3; k++) begin
        if (RootBits'(sm_q[SqrtSteps].c[k]) >= sr_q[SqrtSteps][RootBits-1:0]) begin
          dq_q[0][k]   <= (F+1)'(1);
          drem_q[0][k] <= RootBits'(sm_q[SqrtSteps].c[k]) - sr_q[SqrtSteps][RootBits-1:0];
        end else begin
          dq_q[0][k]   <= '0;
          drem_q[0][k] <= RootBits'(sm_q[SqrtSteps].c[k]);
        end
      end
    end
  end

  for (genvar j = 1; j <= F; j++) begin : g_div
    logic [2:0][RootBits:0] rem2;
    logic [2:0]             ge;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        rem2[k] = {drem_q[j-1][k], 1'b0};
        ge[k]   = rem2[k] >= {1'b0, dr_q[j-1]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else if (en_i) begin
        dv_q[j] <= dv_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dr_q[j] <= dr_q[j-1];
        dm_q[j] <= dm_q[j-1];
        for (int k = 0; k < 3; k++) begin
          dq_q[j][k]   <= {dq_q[j-1][k][F-1:0], ge[k]};
          drem_q[j][k] <= ge[k] ? RootBits'(rem2[k] - {1'b0, dr_q[j-1]})
                                : rem2[k][RootBits-1:0];
        end
      end
    end
  end

  // round half away from zero, restore sign
  logic [2:0][F+1:0] u_d, u_q;
  logic              nz_q, vo_q;

  always_comb begin
    logic [F:0] qf;
    for (int k = 0; k < 3; k++) begin
      qf = dq_q[F][k] + (F+1)'({drem_q[F][k], 1'b0} >= {1'b0, dr_q[F]});
      u_d[k] = dm_q[F].neg[k] ? -{1'b0, qf} : {1'b0, qf};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= dv_q[F];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q  <= u_d;
      nz_q <= dm_q[F].nz;
    end
  end

  assign vld_o = vo_q;
  assign nz_o  = nz_q;
  assign u_o   = u_q;

endmodule

### rtl/ofr_zaxis.sv
module ofr_zaxis #(
  parameter int F = ofr_pkg::OutFracBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic                  deg_i,
  input  logic [2:0][F+1:0]     x_i,
  input  logic [2:0][F+1:0]     y_i,
  output logic                  vld_o,
  output logic                  deg_o,
  output logic [8:0][F+1:0]     ent_o
);
  localparam int OW = F + 2;
  localparam int PW = 2 * OW;
  localparam int DW = PW + 1;
  localparam logic [DW-1:0] Lim  = DW'(1) << F;
  localparam logic [DW-1:0] Half = DW'(1) << (F - 1);

  logic signed [PW-1:0] pa_q [3];
  logic signed [PW-1:0] pb_q [3];
  logic [2:0][DW-1:0]   df_q;
  logic [2:0][OW-1:0]   x1_q, y1_q, x2_q, y2_q;
  logic                 d1_q, d2_q, d3_q;
  logic                 v1_q, v2_q, v3_q;
  logic [8:0][OW-1:0]   ent_d, ent_q;

  // round the exact Q2 difference back to Q1.F and clamp to one
  always_comb begin
    logic [DW-1:0] m;
    logic [DW-1:0] sh;
    logic [OW-1:0] q;
    for (int k = 0; k < 3; k++) begin
      m  = df_q[k][DW-1] ? -df_q[k] : df_q[k];
      sh = (m + Half) >> F;
      q  = (sh > Lim) ? OW'(Lim) : OW'(sh);
      ent_d[6+k] = df_q[k][DW-1] ? -q : q;
      ent_d[k]   = x2_q[k];
      ent_d[3+k] = y2_q[k];
    end
    if (d2_q) ent_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q[0] <= $signed(x_i[1]) * $signed(y_i[2]);
      pb_q[0] <= $signed(x_i[2]) * $signed(y_i[1]);
      pa_q[1] <= $signed(x_i[2]) * $signed(y_i[0]);
      pb_q[1] <= $signed(x_i[0]) * $signed(y_i[2]);
      pa_q[2] <= $signed(x_i[0]) * $signed(y_i[1]);
      pb_q[2] <= $signed(x_i[1]) * $signed(y_i[0]);
      x1_q <= x_i;
      y1_q <= y_i;
      d1_q <= deg_i;
      for (int k = 0; k < 3; k++) begin
        df_q[k] <= DW'(pa_q[k]) - DW'(pb_q[k]);
      end
      x2_q  <= x1_q;
      y2_q  <= y1_q;
      d2_q  <= d1_q;
      ent_q <= ent_d;
      d3_q  <= d2_q;
    end
  end

  assign vld_o = v3_q;
  assign deg_o = d3_q;
  assign ent_o = ent_q;

endmodule

### rtl/orbital_frame_rotation_matrix_unit.sv
// Orbital frame rotation matrix.
// Slave channel: one transaction carries a position and a velocity vector,
// s_axis_tdata = {vel_z, vel_y, vel_x, pos_z, pos_y, pos_x} from the top
// down, IN_WIDTH bits each, two's complement.
// Master channel: one transaction per input with the 3x3 matrix whose
// columns are the unit velocity, the unit (v cross p) and their cross
// product, each entry signed Q1.OUT_FRAC_BITS. m_axis_tuser flags an
// input with zero velocity or velocity parallel to position; all nine
// entries are then zero.
// The cross product comes first, then for each axis the normalization, squares, the
// bit-per-stage square root and the bit-per-stage divide, and last the z axis.
// Throughput is one transaction per cycle while m_axis_tready does not stall the output.
// The whole pipeline advances while the output register is empty or being
// taken; a stall on m_axis_tready with a pending result holds every stage
// and drops s_axis_tready in the same cycle. Reset clears all valid bits.
module orbital_frame_rotation_matrix_unit #(
  parameter int IN_WIDTH      = ofr_pkg::InWidth,
  parameter int OUT_FRAC_BITS = ofr_pkg::OutFracBits
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  input  logic [((6*IN_WIDTH+7)/8)*8-1:0]            s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // m00, m10, m20, m01, m11, m21, m02, m12, m22
  output logic [((9*(OUT_FRAC_BITS+2)+7)/8)*8-1:0]   m_axis_tdata,
  // degenerate
  output logic                                       m_axis_tuser
);
  import ofr_pkg::*;

  localparam int W  = IN_WIDTH;
  localparam int F  = OUT_FRAC_BITS;
  localparam int OW = F + 2;
  localparam int CW = 2 * W + 1;
  localparam int TW = ((9 * OW + 7) / 8) * 8;

  logic                 en;
  logic [2:0][W-1:0]    pos, vel, vel_d;
  logic [2:0][CW-1:0]   cr;
  logic                 cv;
  logic                 xv, xnz, yv, ynz;
  logic [2:0][OW-1:0]   xu, yu;
  logic [8:0][OW-1:0]   ent;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign pos           = s_axis_tdata[3*W-1:0];
  assign vel           = s_axis_tdata[6*W-1:3*W];

  ofr_cross #(.W(W)) u_cross (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s_axis_tvalid),
    .pos_i(pos), .vel_i(vel),
    .vld_o(cv), .vel_o(vel_d), .cr_o(cr)
  );

  ofr_unit #(.W(W), .F(F)) u_xaxis (
    .clk_i, .rst_ni, .en_i(en), .vld_i(cv), .a_i(vel_d),
    .vld_o(xv), .nz_o(xnz), .u_o(xu)
  );

  ofr_unit #(.W(CW), .F(F)) u_yaxis (
    .clk_i, .rst_ni, .en_i(en), .vld_i(cv), .a_i(cr),
    .vld_o(yv), .nz_o(ynz), .u_o(yu)
  );

  ofr_zaxis #(.F(F)) u_zaxis (
    .clk_i, .rst_ni, .en_i(en), .vld_i(xv), .deg_i(!(xnz && ynz)),
    .x_i(xu), .y_i(yu),
    .vld_o(m_axis_tvalid), .deg_o(m_axis_tuser), .ent_o(ent)
  );

  assign m_axis_tdata = TW'(ent);

  localparam logic signed [OW-1:0] One = OW'(1) << F;

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate result with nonzero entries");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_axes_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xv == yv)
    else $error("x and y axis pipelines out of step");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      $signed(ent[0]) <= One && $signed(ent[0]) >= -One)
    else $error("x axis entry outside unit range");

endmodule
